@@ hdl/ets_pkg.sv @@
// ets_pkg: shared types and constants for the escaped token splitter
// used by the channel interfaces, the classifier and the top level
`default_nettype none
package ets_pkg;

  localparam int UNIT_W      = 16;
  localparam int CFG_W       = 64;
  localparam int COUNT_W     = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int STATUS_W    = 2;
  localparam int SET_ENTRIES_DEF = 4;

  // result queue geometry
  localparam int FIFO_DEPTH  = 4;
  localparam int PTR_W       = 2;
  localparam int CNT_W       = 3;

  localparam logic [UNIT_W-1:0] ESC_UNIT = 16'h005C;
  localparam logic [UNIT_W-1:0] EOS_UNIT = 16'h0000;

  // token status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EOS    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BSEND  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FORBID = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STOP_SET        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FORBIDDEN_SET   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FORBIDDEN_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_SET        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_COUNT      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_ALL        = 3'd6;

  typedef struct packed {
    logic [UNIT_W-1:0]   out_char;
    logic                char_valid;
    logic                token_end;
    logic [STATUS_W-1:0] status;
    logic                last;
  } result_t;

  typedef struct packed {
    logic escape_pending;
    logic at_token_start;
  } scan_state_t;

endpackage
`default_nettype wire

@@ hdl/ets_if.sv @@
// ets_if: valid/ready channel interfaces for code units and token results
// depends on ets_pkg for field widths
`default_nettype none
interface ets_in_if;
  logic                      valid;
  logic                      ready;
  logic [ets_pkg::UNIT_W-1:0] code_unit;

  modport source (output valid, output code_unit, input ready);
  modport sink   (input valid, input code_unit, output ready);
endinterface

interface ets_out_if;
  logic                        valid;
  logic                        ready;
  logic [ets_pkg::UNIT_W-1:0]   out_char;
  logic                        char_valid;
  logic                        token_end;
  logic [ets_pkg::STATUS_W-1:0] status;
  logic                        last;

  modport source (output valid, output out_char, output char_valid, output token_end,
                  output status, output last, input ready);
  modport sink   (input valid, input out_char, input char_valid, input token_end,
                  input status, input last, output ready);
endinterface
`default_nettype wire

@@ hdl/ets_classify.sv @@
// ets_classify: one-item decision logic, set compares and result forming
// depends on ets_pkg for result and state types
`default_nettype none
module ets_classify #(
  parameter int SET_ENTRIES = ets_pkg::SET_ENTRIES_DEF
) (
  input  wire logic [ets_pkg::UNIT_W-1:0]  code,
  input  wire ets_pkg::scan_state_t        cur,
  input  wire logic [ets_pkg::UNIT_W-1:0]  stop_set      [SET_ENTRIES],
  input  wire logic [ets_pkg::COUNT_W-1:0] stop_count,
  input  wire logic [ets_pkg::UNIT_W-1:0]  forbidden_set [SET_ENTRIES],
  input  wire logic [ets_pkg::COUNT_W-1:0] forbidden_count,
  input  wire logic [ets_pkg::UNIT_W-1:0]  keep_set      [SET_ENTRIES],
  input  wire logic [ets_pkg::COUNT_W-1:0] keep_count,
  input  wire logic                        keep_all,
  output ets_pkg::scan_state_t             nxt,
  output logic [1:0]                       res_n,
  output ets_pkg::result_t                 res0,
  output ets_pkg::result_t                 res1
);

  logic stop_hit;
  logic forbid_hit;
  logic keep_hit;

  // entries at or above the count are ignored
  always_comb begin
    stop_hit   = 1'b0;
    forbid_hit = 1'b0;
    keep_hit   = 1'b0;
    for (int i = 0; i < SET_ENTRIES; i++) begin
      if ((ets_pkg::COUNT_W'(i) < stop_count) && (stop_set[i] == code))
        stop_hit = 1'b1;
      if ((ets_pkg::COUNT_W'(i) < forbidden_count) && (forbidden_set[i] == code))
        forbid_hit = 1'b1;
      if ((ets_pkg::COUNT_W'(i) < keep_count) && (keep_set[i] == code))
        keep_hit = 1'b1;
    end
  end

  always_comb begin
    nxt   = cur;
    res_n = 2'd0;
    res0  = '0;
    res1  = '0;
    if (cur.escape_pending) begin
      nxt.escape_pending = 1'b0;
      if (code == ets_pkg::EOS_UNIT) begin
        nxt.at_token_start = 1'b1;
        res_n = 2'd1;
        res0  = '{out_char: '0, char_valid: 1'b0, token_end: 1'b1,
                  status: ets_pkg::ST_BSEND, last: 1'b1};
      end else if (keep_all || keep_hit) begin
        nxt.at_token_start = 1'b0;
        res_n = 2'd2;
        res0  = '{out_char: ets_pkg::ESC_UNIT, char_valid: 1'b1, token_end: 1'b0,
                  status: ets_pkg::ST_OK, last: 1'b0};
        res1  = '{out_char: code, char_valid: 1'b1, token_end: 1'b0,
                  status: ets_pkg::ST_OK, last: 1'b1};
      end else begin
        nxt.at_token_start = 1'b0;
        res_n = 2'd1;
        res0  = '{out_char: code, char_valid: 1'b1, token_end: 1'b0,
                  status: ets_pkg::ST_OK, last: 1'b1};
      end
    end else if (code == ets_pkg::EOS_UNIT) begin
      nxt.at_token_start = 1'b1;
      res_n = 2'd1;
      res0  = '{out_char: '0, char_valid: 1'b0, token_end: 1'b1,
                status: cur.at_token_start ? ets_pkg::ST_EOS : ets_pkg::ST_OK,
                last: 1'b1};
    end else if (code == ets_pkg::ESC_UNIT) begin
      nxt.escape_pending = 1'b1;
      nxt.at_token_start = 1'b0;
    end else if (stop_hit) begin
      nxt.at_token_start = 1'b1;
      res_n = 2'd1;
      res0  = '{out_char: '0, char_valid: 1'b0, token_end: 1'b1,
                status: ets_pkg::ST_OK, last: 1'b1};
    end else if (forbid_hit) begin
      nxt.at_token_start = 1'b1;
      res_n = 2'd1;
      res0  = '{out_char: '0, char_valid: 1'b0, token_end: 1'b1,
                status: ets_pkg::ST_FORBID, last: 1'b1};
    end else begin
      nxt.at_token_start = 1'b0;
      res_n = 2'd1;
      res0  = '{out_char: code, char_valid: 1'b1, token_end: 1'b0,
                status: ets_pkg::ST_OK, last: 1'b1};
    end
  end

endmodule
`default_nettype wire

@@ hdl/escaped_token_splitter_top.sv @@
// escaped_token_splitter_top: code units pass an input register stage, then the result queue
// throughput: one code unit per cycle while the queue has room; an escaped unit whose
// backslash is kept yields two results, paced by the output handshake at one result per cycle
// the four-entry result queue must have room for two results before the input stage advances
// synchronous active-high rst clears scan state, queue and config (keep_all resets to 1)
// depends on ets_pkg, ets_if (ets_in_if, ets_out_if) and ets_classify
`default_nettype none
module escaped_token_splitter_top #(
  parameter int SET_ENTRIES = ets_pkg::SET_ENTRIES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  ets_in_if.sink                             units,
  ets_out_if.source                          tokens,
  input  wire logic                          cfg_we,
  input  wire logic [ets_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ets_pkg::CFG_W-1:0]     cfg_data
);

  // configuration registers; only the first SET_ENTRIES characters of each set are stored
  logic [ets_pkg::UNIT_W-1:0]  stop_set      [SET_ENTRIES];
  logic [ets_pkg::UNIT_W-1:0]  forbidden_set [SET_ENTRIES];
  logic [ets_pkg::UNIT_W-1:0]  keep_set      [SET_ENTRIES];
  logic [ets_pkg::COUNT_W-1:0] stop_count;
  logic [ets_pkg::COUNT_W-1:0] forbidden_count;
  logic [ets_pkg::COUNT_W-1:0] keep_count;
  logic                        keep_all;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SET_ENTRIES; i++) begin
        stop_set[i]      <= '0;
        forbidden_set[i] <= '0;
        keep_set[i]      <= '0;
      end
      stop_count      <= '0;
      forbidden_count <= '0;
      keep_count      <= '0;
      keep_all        <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ets_pkg::REG_STOP_SET: begin
          for (int i = 0; i < SET_ENTRIES; i++)
            stop_set[i] <= cfg_data[i*ets_pkg::UNIT_W +: ets_pkg::UNIT_W];
        end
        ets_pkg::REG_STOP_COUNT:      stop_count <= cfg_data[ets_pkg::COUNT_W-1:0];
        ets_pkg::REG_FORBIDDEN_SET: begin
          for (int i = 0; i < SET_ENTRIES; i++)
            forbidden_set[i] <= cfg_data[i*ets_pkg::UNIT_W +: ets_pkg::UNIT_W];
        end
        ets_pkg::REG_FORBIDDEN_COUNT: forbidden_count <= cfg_data[ets_pkg::COUNT_W-1:0];
        ets_pkg::REG_KEEP_SET: begin
          for (int i = 0; i < SET_ENTRIES; i++)
            keep_set[i] <= cfg_data[i*ets_pkg::UNIT_W +: ets_pkg::UNIT_W];
        end
        ets_pkg::REG_KEEP_COUNT:      keep_count <= cfg_data[ets_pkg::COUNT_W-1:0];
        ets_pkg::REG_KEEP_ALL:        keep_all <= cfg_data[0];
        default: ; // writes past the register list are dropped
      endcase
    end
  end

  // input register stage
  logic                       s1_valid;
  logic [ets_pkg::UNIT_W-1:0] s1_code;
  logic                       fire;

  // result queue: four entries, up to two pushes and one pop per cycle
  ets_pkg::result_t           fifo [ets_pkg::FIFO_DEPTH];
  logic [ets_pkg::PTR_W-1:0]  rd_ptr;
  logic [ets_pkg::PTR_W-1:0]  wr_ptr;
  logic [ets_pkg::CNT_W-1:0]  count;
  logic [ets_pkg::CNT_W-1:0]  count_next;
  logic                       pop;

  // scan state carried across items
  ets_pkg::scan_state_t       scan;
  ets_pkg::scan_state_t       scan_next;
  logic [1:0]                 push_n;
  ets_pkg::result_t           res0;
  ets_pkg::result_t           res1;

  // the stage moves on only when the queue can take a two-result item
  assign fire        = s1_valid && (count <= ets_pkg::CNT_W'(ets_pkg::FIFO_DEPTH - 2));
  assign units.ready = !s1_valid || fire;
  assign pop         = tokens.valid && tokens.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (units.valid && units.ready) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (units.valid && units.ready) begin
      s1_code <= units.code_unit;
    end
  end

  ets_classify #(
    .SET_ENTRIES (SET_ENTRIES)
  ) u_classify (
    .code            (s1_code),
    .cur             (scan),
    .stop_set        (stop_set),
    .stop_count      (stop_count),
    .forbidden_set   (forbidden_set),
    .forbidden_count (forbidden_count),
    .keep_set        (keep_set),
    .keep_count      (keep_count),
    .keep_all        (keep_all),
    .nxt             (scan_next),
    .res_n           (push_n),
    .res0            (res0),
    .res1            (res1)
  );

  // escape flag and token-start flag advance once per processed item
  always_ff @(posedge clk) begin
    if (rst) begin
      scan.escape_pending <= 1'b0;
      scan.at_token_start <= 1'b1;
    end else if (fire) begin
      scan <= scan_next;
    end
  end

  // queue payload, no reset
  always_ff @(posedge clk) begin
    if (fire && (push_n != 2'd0)) begin
      fifo[wr_ptr] <= res0;
    end
    if (fire && (push_n == 2'd2)) begin
      fifo[ets_pkg::PTR_W'(wr_ptr + 1'b1)] <= res1;
    end
  end

  always_comb begin
    count_next = count;
    if (fire)
      count_next = ets_pkg::CNT_W'(count_next + ets_pkg::CNT_W'(push_n));
    if (pop)
      count_next = ets_pkg::CNT_W'(count_next - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (fire)
        wr_ptr <= ets_pkg::PTR_W'(wr_ptr + push_n);
      if (pop)
        rd_ptr <= ets_pkg::PTR_W'(rd_ptr + 1'b1);
      count <= count_next;
    end
  end

  // head of the queue drives the output channel
  assign tokens.valid      = (count != '0);
  assign tokens.out_char   = fifo[rd_ptr].out_char;
  assign tokens.char_valid = fifo[rd_ptr].char_valid;
  assign tokens.token_end  = fifo[rd_ptr].token_end;
  assign tokens.status     = fifo[rd_ptr].status;
  assign tokens.last       = fifo[rd_ptr].last;

  // queue never overfills
  assert property (@(posedge clk) disable iff (rst)
    count <= ets_pkg::CNT_W'(ets_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  // a non-final result always has its partner already queued behind it
  assert property (@(posedge clk) disable iff (rst)
    pop && !tokens.last |-> count >= ets_pkg::CNT_W'(2))
    else $error("first half of a result pair left without its partner");

  // a token-closing result never carries a character
  assert property (@(posedge clk) disable iff (rst)
    tokens.valid && tokens.token_end |-> !tokens.char_valid)
    else $error("token end with a character attached");

  // a pending escape always sits inside a token
  assert property (@(posedge clk) disable iff (rst)
    scan.escape_pending |-> !scan.at_token_start)
    else $error("escape pending at token start");

endmodule
`default_nettype wire
